// File: rtl/core/buddy_block_allocator_top_assert.svh
// Assertion macros for the buddy block allocator.
// Used by buddy_block_allocator_top; empty when SYNTHESIS is defined.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/bba_pkg.sv
// Package for the buddy block allocator: sizes, status codes, list slot math.
// No dependencies.
package bba_pkg;
	localparam int POOL_ORDER = 10;
	localparam int POOL_SIZE  = 1 << POOL_ORDER;
	localparam int STORE_SIZE = 1 << (POOL_ORDER + 1);
	localparam int IDX_W = POOL_ORDER;
	localparam int SA_W  = POOL_ORDER + 1;
	localparam int CNT_W = POOL_ORDER + 1;
	localparam int ORD_W = 4;
	localparam int USED_W = ORD_W + 1;
	localparam logic [SA_W-1:0] TOP_SLOT = SA_W'(STORE_SIZE - 2);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	localparam logic FUNC_ALLOC = 1'b0;

	// Capacity of the circular region that holds the list of order k.
	function automatic logic [CNT_W-1:0] region_cap(logic [ORD_W-1:0] k);
		return CNT_W'(1) << (POOL_ORDER - int'(k));
	endfunction

	// Store address of position pos in the list of order k.
	function automatic logic [SA_W-1:0] slot_addr(logic [ORD_W-1:0] k,
			logic [IDX_W-1:0] head, logic [CNT_W-1:0] pos);
		logic [SA_W:0] base;
		logic [CNT_W-1:0] sum;
		base = (SA_W+1)'(STORE_SIZE) - ((SA_W+1)'(1) << (POOL_ORDER + 1 - int'(k)));
		sum = (CNT_W'(head) + pos) & (region_cap(k) - CNT_W'(1));
		return SA_W'(base + (SA_W+1)'(sum));
	endfunction
endpackage

// File: rtl/core/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/buddy_block_allocator_top.sv
// Buddy block allocator over a pool of 1024 elements, one FIFO free list per order.
// Depends on bba_pkg, bba_ram and buddy_block_allocator_top_assert.svh.
//
// After reset the block clears all 1024 entries of the used table and holds
// in_stall high meanwhile. One item is worked at a time. A rejected allocate
// ends at decode and a free of an unallocated index at the used-table check.
// A granted allocate pops the head of the source list and then splits once
// per order down to the requested one. A free checks the used table, then at
// each merge level scans the list of that order up to the buddy and moves the
// later entries forward to close the gap, and at last appends the block to its
// list; every list access goes through the single read port of the free-list memory.
// A finished result waits in the output register while the next item is taken.
`include "buddy_block_allocator_top_assert.svh"
module buddy_block_allocator_top
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [15:0]       req_size,
	input  logic [IDX_W-1:0]  release_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  block_index,
	output logic [ORD_W-1:0]  block_order
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_POP_WAIT, S_SPLIT, S_FREE_CHK, S_MERGE, S_SCAN,
		S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_DONE
	} state_t;

	state_t state_q;
	logic clr_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic top_wr_q;
	logic rd_top_s1;
	logic [IDX_W-1:0] head_q [POOL_ORDER+1];
	logic [CNT_W-1:0] count_q [POOL_ORDER+1];
	logic func_q;
	logic [15:0] size_q;
	logic [IDX_W-1:0] rel_q;
	logic [IDX_W-1:0] blk_q;
	logic [ORD_W-1:0] ord_q;
	logic [ORD_W-1:0] lvl_q;
	logic [CNT_W-1:0] pos_q;
	status_t res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [ORD_W-1:0] res_ord_q;
	logic out_valid_q;
	status_t out_status_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [ORD_W-1:0] out_ord_q;

	// Free-list memory ports.
	logic fl_we;
	logic [SA_W-1:0] fl_waddr, fl_raddr;
	logic [IDX_W-1:0] fl_wdata, fl_rdata, fl_data;
	// Used-table memory ports.
	logic us_we;
	logic [IDX_W-1:0] us_waddr, us_raddr;
	logic [USED_W-1:0] us_wdata, us_rdata;

	bba_ram #(.WIDTH(IDX_W), .DEPTH(STORE_SIZE)) u_free_list (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rdata)
	);

	bba_ram #(.WIDTH(USED_W), .DEPTH(POOL_SIZE)) u_used (
		.clk(clk), .we(us_we), .waddr(us_waddr), .wdata(us_wdata),
		.raddr(us_raddr), .rdata(us_rdata)
	);

	// The single entry of the top list holds block zero until first written.
	assign fl_data = rd_top_s1 ? '0 : fl_rdata;

	// Rounded order of the request and the smallest usable list.
	logic [15:0] size_m1;
	logic [4:0] req_ord;
	logic [ORD_W-1:0] src_lvl;
	logic src_found;
	logic [IDX_W-1:0] buddy;
	logic [ORD_W-1:0] lvl_dn;

	always_comb begin
		size_m1 = (size_q == 16'd0) ? 16'd0 : size_q - 16'd1;
		req_ord = '0;
		for (int i = 0; i < 16; i++) begin
			if (size_m1[i]) begin
				req_ord = 5'(i + 1);
			end
		end
		src_lvl = '0;
		src_found = 1'b0;
		for (int k = POOL_ORDER; k >= 0; k--) begin
			if (5'(k) >= req_ord && count_q[k] != '0) begin
				src_lvl = ORD_W'(k);
				src_found = 1'b1;
			end
		end
		buddy = blk_q ^ (IDX_W'(1) << lvl_q);
		lvl_dn = lvl_q - ORD_W'(1);
	end

	always_comb begin
		fl_we = 1'b0;
		fl_waddr = '0;
		fl_wdata = '0;
		fl_raddr = '0;
		us_we = 1'b0;
		us_waddr = '0;
		us_wdata = '0;
		us_raddr = rel_q;
		if (clr_q) begin
			us_we = 1'b1;
			us_waddr = clr_idx_q;
		end
		case (state_q)
			S_DECODE: begin
				fl_raddr = slot_addr(src_lvl, head_q[src_lvl], '0);
			end
			S_SPLIT: begin
				if (lvl_q > ord_q) begin
					fl_waddr = slot_addr(lvl_dn, head_q[lvl_dn], count_q[lvl_dn]);
					fl_wdata = blk_q + (IDX_W'(1) << lvl_dn);
					fl_we = count_q[lvl_dn] < region_cap(lvl_dn);
				end else begin
					us_we = 1'b1;
					us_waddr = blk_q;
					us_wdata = {1'b1, ord_q};
				end
			end
			S_FREE_CHK: begin
				if (us_rdata[USED_W-1]) begin
					us_we = 1'b1;
					us_waddr = rel_q;
				end
			end
			S_SCAN: begin
				fl_raddr = slot_addr(lvl_q, head_q[lvl_q], pos_q);
			end
			S_SHIFT_RD: begin
				fl_raddr = slot_addr(lvl_q, head_q[lvl_q], pos_q + CNT_W'(1));
			end
			S_SHIFT_WR: begin
				fl_we = 1'b1;
				fl_waddr = slot_addr(lvl_q, head_q[lvl_q], pos_q);
				fl_wdata = fl_data;
			end
			S_APPEND: begin
				fl_waddr = slot_addr(lvl_q, head_q[lvl_q], count_q[lvl_q]);
				fl_wdata = blk_q;
				fl_we = count_q[lvl_q] < region_cap(lvl_q);
			end
			default: begin
			end
		endcase
	end

	assign in_stall = clr_q || (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			top_wr_q <= 1'b0;
			rd_top_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= POOL_ORDER; k++) begin
				head_q[k] <= '0;
				count_q[k] <= (k == POOL_ORDER) ? CNT_W'(1) : '0;
			end
		end else begin
			rd_top_s1 <= (fl_raddr == TOP_SLOT) && !top_wr_q;
			if (fl_we && fl_waddr == TOP_SLOT) begin
				top_wr_q <= 1'b1;
			end
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(POOL_SIZE - 1)) begin
					clr_q <= 1'b0;
				end
			end
			// A result finishing now reloads the output register instead.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q <= func;
						size_q <= req_size;
						rel_q <= release_index;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_idx_q <= '0;
					res_ord_q <= '0;
					if (func_q != FUNC_ALLOC) begin
						state_q <= S_FREE_CHK;
					end else if (req_ord > 5'(POOL_ORDER)) begin
						res_status_q <= ST_TOO_LARGE;
						state_q <= S_DONE;
					end else if (!src_found) begin
						res_status_q <= ST_NO_FREE;
						state_q <= S_DONE;
					end else begin
						head_q[src_lvl] <= (head_q[src_lvl] + IDX_W'(1))
							& IDX_W'(region_cap(src_lvl) - CNT_W'(1));
						count_q[src_lvl] <= count_q[src_lvl] - CNT_W'(1);
						ord_q <= ORD_W'(req_ord);
						lvl_q <= src_lvl;
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					blk_q <= fl_data;
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (lvl_q > ord_q) begin
						if (fl_we) begin
							count_q[lvl_dn] <= count_q[lvl_dn] + CNT_W'(1);
						end
						lvl_q <= lvl_dn;
					end else begin
						res_status_q <= ST_OK;
						res_idx_q <= blk_q;
						res_ord_q <= ord_q;
						state_q <= S_DONE;
					end
				end
				S_FREE_CHK: begin
					if (!us_rdata[USED_W-1]) begin
						res_status_q <= ST_NOT_ALLOC;
						state_q <= S_DONE;
					end else begin
						res_status_q <= ST_OK;
						res_idx_q <= rel_q;
						blk_q <= rel_q;
						if (us_rdata[ORD_W-1:0] > ORD_W'(POOL_ORDER)) begin
							res_ord_q <= ORD_W'(POOL_ORDER);
							lvl_q <= ORD_W'(POOL_ORDER);
						end else begin
							res_ord_q <= us_rdata[ORD_W-1:0];
							lvl_q <= us_rdata[ORD_W-1:0];
						end
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					pos_q <= '0;
					state_q <= (lvl_q == ORD_W'(POOL_ORDER)) ? S_APPEND : S_SCAN;
				end
				S_SCAN: begin
					state_q <= (pos_q == count_q[lvl_q]) ? S_APPEND : S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (fl_data == buddy) begin
						state_q <= S_SHIFT_RD;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_SHIFT_RD: begin
					if (pos_q + CNT_W'(1) < count_q[lvl_q]) begin
						state_q <= S_SHIFT_WR;
					end else begin
						// Buddy removed: merge into the lower of the pair.
						count_q[lvl_q] <= count_q[lvl_q] - CNT_W'(1);
						if (buddy < blk_q) begin
							blk_q <= buddy;
						end
						lvl_q <= lvl_q + ORD_W'(1);
						state_q <= S_MERGE;
					end
				end
				S_SHIFT_WR: begin
					pos_q <= pos_q + CNT_W'(1);
					state_q <= S_SHIFT_RD;
				end
				S_APPEND: begin
					if (fl_we) begin
						count_q[lvl_q] <= count_q[lvl_q] + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q <= res_idx_q;
						out_ord_q <= res_ord_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign block_index = out_idx_q;
	assign block_order = out_ord_q;

	`BBA_ASSERT_IMP(a_busy_not_clearing, clk, arst_n, state_q != S_IDLE, !clr_q)
	`BBA_ASSERT_IMP(a_top_list_bound, clk, arst_n, 1'b1, count_q[POOL_ORDER] <= CNT_W'(1))
	`BBA_ASSERT_IMP(a_error_zero_fields, clk, arst_n,
		out_valid_q && out_status_q != ST_OK, out_idx_q == '0 && out_ord_q == '0)
	`BBA_ASSERT_NXT(a_accept_decodes, clk, arst_n, in_valid && !in_stall, state_q == S_DECODE)
endmodule

// File: test/buddy_block_allocator_top_test.sv
// Self-checking bench for the buddy block allocator: directed and random
// allocate/free traffic checked against an in-bench buddy model.
// Depends on bba_pkg and buddy_block_allocator_top.
module buddy_block_allocator_top_test;
	import bba_pkg::*;

	typedef struct packed {
		status_t          st;
		logic [IDX_W-1:0] idx;
		logic [ORD_W-1:0] ord;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = FUNC_ALLOC;
	logic [15:0] req_size = '0;
	logic [IDX_W-1:0] release_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [IDX_W-1:0] block_index;
	logic [ORD_W-1:0] block_order;

	buddy_block_allocator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .req_size(req_size), .release_index(release_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .block_index(block_index), .block_order(block_order)
	);

	// Model state: per-order FIFO lists plus the used table.
	logic [IDX_W-1:0] free_lists [POOL_ORDER+1][$];
	logic             used_flag [POOL_SIZE];
	logic [ORD_W-1:0] used_ord [POOL_SIZE];
	logic [IDX_W-1:0] live_blocks [$];

	alloc_result_t expected_results [$];
	int error_count = 0;
	int accepted_count = 0;
	int result_count = 0;
	int cycle_count = 0;
	bit long_hold = 1'b0;
	bit gap_enable = 1'b1;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("%0t: timeout, %0d results pending", $time, expected_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void model_reset();
		for (int k = 0; k <= POOL_ORDER; k++)
			free_lists[k].delete();
		free_lists[POOL_ORDER].insert(0, '0);
		for (int i = 0; i < POOL_SIZE; i++) begin
			used_flag[i] = 1'b0;
			used_ord[i] = '0;
		end
		live_blocks.delete();
	endfunction

	function automatic alloc_result_t predict_allocation(logic f, logic [15:0] sz,
			logic [IDX_W-1:0] ri);
		alloc_result_t r;
		int o;
		int j;
		int blk;
		int buddy;
		bit found;
		r = '{st: ST_OK, idx: '0, ord: '0};
		if (f == FUNC_ALLOC) begin
			o = 0;
			while ((1 << o) < ((sz == 0) ? 1 : int'(sz)))
				o++;
			if (o > POOL_ORDER) begin
				r.st = ST_TOO_LARGE;
				return r;
			end
			j = o;
			while (j <= POOL_ORDER && free_lists[j].size() == 0)
				j++;
			if (j > POOL_ORDER) begin
				r.st = ST_NO_FREE;
				return r;
			end
			blk = free_lists[j][0];
			free_lists[j].delete(0);
			while (j > o) begin
				j--;
				free_lists[j].insert(free_lists[j].size(), IDX_W'(blk + (1 << j)));
			end
			used_flag[blk] = 1'b1;
			used_ord[blk] = ORD_W'(o);
			live_blocks.insert(live_blocks.size(), IDX_W'(blk));
			r.idx = IDX_W'(blk);
			r.ord = ORD_W'(o);
		end else begin
			if (!used_flag[ri]) begin
				r.st = ST_NOT_ALLOC;
				return r;
			end
			o = used_ord[ri];
			blk = ri;
			used_flag[ri] = 1'b0;
			for (int i = 0; i < live_blocks.size(); i++)
				if (live_blocks[i] == ri) begin
					live_blocks.delete(i);
					break;
				end
			r.idx = ri;
			r.ord = ORD_W'(o);
			while (o < POOL_ORDER) begin
				buddy = blk ^ (1 << o);
				found = 1'b0;
				for (int i = 0; i < free_lists[o].size(); i++)
					if (free_lists[o][i] == buddy) begin
						free_lists[o].delete(i);
						found = 1'b1;
						break;
					end
				if (!found)
					break;
				if (buddy < blk)
					blk = buddy;
				o++;
			end
			free_lists[o].insert(free_lists[o].size(), IDX_W'(blk));
		end
		return r;
	endfunction

	// Sends one item in a burst-and-gap pattern, predicting at acceptance.
	// Valid stays high after acceptance until a gap or a drain lowers it.
	task automatic send_item(logic f, logic [15:0] sz, logic [IDX_W-1:0] ri);
		if (gap_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		func <= f;
		req_size <= sz;
		release_index <= ri;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.insert(expected_results.size(), predict_allocation(f, sz, ri));
		accepted_count++;
		@(negedge clk);
	endtask

	task automatic send_alloc(logic [15:0] sz);
		send_item(FUNC_ALLOC, sz, IDX_W'($urandom));
	endtask

	task automatic send_free(logic [IDX_W-1:0] ri);
		send_item(~FUNC_ALLOC, 16'($urandom), ri);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic free_everything();
		while (live_blocks.size() != 0)
			send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
	endtask

	task automatic test_directed_edges();
		send_alloc(16'd0);
		send_alloc(16'd1);
		send_alloc(16'd3);
		send_alloc(16'd1025);
		send_alloc(16'hFFFF);
		send_free(10'd5);
		send_free(10'h3FF);
		send_free(live_blocks[0]);
		send_free(live_blocks[0]);
		free_everything();
		send_alloc(16'd1024);
		send_alloc(16'd1);
		send_free(10'd0);
		send_alloc(16'd512);
		send_alloc(16'd512);
		send_alloc(16'd1);
		free_everything();
		wait_drained();
	endtask

	task automatic test_exhaust_pool();
		repeat (70)
			send_alloc(16'($urandom_range(1, 32)));
		send_alloc(16'd1);
		free_everything();
		wait_drained();
	endtask

	task automatic test_random_mix(int n);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45)
				send_alloc(16'(1 << $urandom_range(0, 6)) - 16'($urandom_range(0, 1)));
			else if (roll < 50)
				send_alloc(16'($urandom));
			else if (roll < 90 && live_blocks.size() != 0)
				send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
			else
				send_free(IDX_W'($urandom));
			// Occasionally drop everything so large blocks coalesce again.
			if ($urandom_range(0, 199) == 0)
				free_everything();
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		long_hold = 1'b1;
		gap_enable = 1'b0;
		repeat (20)
			send_alloc(16'($urandom_range(1, 8)));
		gap_enable = 1'b1;
		long_hold = 1'b0;
		free_everything();
		wait_drained();
	endtask

	// Receiver stall pattern, plus a long counted hold-off on request.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
				out_stall <= 1'b0;
				wait (!long_hold);
			end else if ((cycle_count / 500) % 4 == 0)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			result_count <= result_count + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status %0d index %0d order %0d",
					$time, status, block_index, block_order);
				error_count++;
			end else begin
				exp_r = expected_results[0];
				expected_results.delete(0);
				if (status !== exp_r.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
					error_count++;
				end
				if (block_index !== exp_r.idx) begin
					$display("%0t: block_index expected %0d actual %0d",
						$time, exp_r.idx, block_index);
					error_count++;
				end
				if (block_order !== exp_r.ord) begin
					$display("%0t: block_order expected %0d actual %0d",
						$time, exp_r.ord, block_order);
					error_count++;
				end
			end
		end
	end

	initial begin
		model_reset();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_edges();
		test_exhaust_pool();
		test_output_backpressure();
		test_random_mix(1400);
		wait_drained();
		repeat (200) @(negedge clk);
		$display("Sent %0d items, checked %0d results: allocation, freeing with merges,",
			accepted_count, result_count);
		$display("exhaustion, oversize and unknown-index errors under stalls.");
		if (error_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/buddy_block_allocator_top.sv
test/buddy_block_allocator_top_test.sv
